[sv/slcan_pkg.sv]
// Shared types, character codes and helpers for the SLCAN frame encoder.
// No dependencies. Used by slcan_ctrl, slcan_dp and can_frame_to_slcan_ascii.
package slcan_pkg;

  localparam logic [7:0] CharStd = 8'h74;  // 't'
  localparam logic [7:0] CharExt = 8'h54;  // 'T'
  localparam logic [7:0] CharCr  = 8'h0D;
  localparam logic [7:0] CharZero = 8'h30; // '0'
  localparam logic [7:0] CharLowA = 8'h61; // 'a'
  localparam logic [3:0] MaxLen  = 4'd8;
  localparam logic [3:0] ExtDigitTop = 4'd7;
  localparam logic [3:0] StdDigitTop = 4'd2;

  typedef enum logic [2:0] {
    SEL_HEAD = 3'd0,
    SEL_ID   = 3'd1,
    SEL_LEN  = 3'd2,
    SEL_DATA = 3'd3,
    SEL_CR   = 3'd4
  } char_sel_e;

  typedef enum logic [2:0] {
    CNT_HOLD    = 3'd0,
    CNT_LOAD_ID = 3'd1,
    CNT_CLEAR   = 3'd2,
    CNT_INC     = 3'd3,
    CNT_DEC     = 3'd4
  } cnt_op_e;

  typedef struct packed {
    logic      load_frame;
    logic      emit;
    char_sel_e sel;
    cnt_op_e   cnt_op;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic cnt_zero;
    logic data_last;
    logic len_zero;
  } status_t;

  // Lower-case hex character for one nibble.
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] ch;
    if (nib < 4'd10) begin
      ch = CharZero + {4'b0000, nib};
    end else begin
      ch = CharLowA + {4'b0000, nib - 4'd10};
    end
    return ch;
  endfunction

endpackage

[sv/slcan_ctrl.sv]
// Sequencer for the SLCAN frame encoder: walks header, identifier digits,
// length digit, data nibbles and CR. Depends on slcan_pkg.
module slcan_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  slcan_pkg::status_t  status_i,
  output logic                in_stall_o,
  output slcan_pkg::cmd_t     cmd_o
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_HEAD = 6'b000010,
    ST_ID   = 6'b000100,
    ST_LEN  = 6'b001000,
    ST_DATA = 6'b010000,
    ST_CR   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d           = state_q;
    cmd_o.load_frame  = 1'b0;
    cmd_o.emit        = 1'b0;
    cmd_o.sel         = slcan_pkg::SEL_HEAD;
    cmd_o.cnt_op      = slcan_pkg::CNT_HOLD;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_frame = 1'b1;
          state_d          = ST_HEAD;
        end
      end
      ST_HEAD: begin
        cmd_o.sel = slcan_pkg::SEL_HEAD;
        if (status_i.out_free) begin
          cmd_o.emit   = 1'b1;
          cmd_o.cnt_op = slcan_pkg::CNT_LOAD_ID;
          state_d      = ST_ID;
        end
      end
      ST_ID: begin
        cmd_o.sel = slcan_pkg::SEL_ID;
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (status_i.cnt_zero) begin
            state_d = ST_LEN;
          end else begin
            cmd_o.cnt_op = slcan_pkg::CNT_DEC;
          end
        end
      end
      ST_LEN: begin
        cmd_o.sel = slcan_pkg::SEL_LEN;
        if (status_i.out_free) begin
          cmd_o.emit   = 1'b1;
          cmd_o.cnt_op = slcan_pkg::CNT_CLEAR;
          state_d      = status_i.len_zero ? ST_CR : ST_DATA;
        end
      end
      ST_DATA: begin
        cmd_o.sel = slcan_pkg::SEL_DATA;
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (status_i.data_last) begin
            state_d = ST_CR;
          end else begin
            cmd_o.cnt_op = slcan_pkg::CNT_INC;
          end
        end
      end
      ST_CR: begin
        cmd_o.sel = slcan_pkg::SEL_CR;
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[sv/slcan_dp.sv]
// Datapath for the SLCAN frame encoder: frame registers, digit counter,
// character select and output register. Depends on slcan_pkg.
module slcan_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  slcan_pkg::cmd_t    cmd_i,
  output slcan_pkg::status_t status_o,
  input  logic               is_extended_i,
  input  logic [28:0]        can_id_i,
  input  logic [3:0]         dlc_i,
  input  logic [7:0]         data_i [8],
  input  logic               out_stall_i,
  output logic               out_valid_o,
  output logic [7:0]         ascii_byte_o,
  output logic               last_byte_o
);

  logic        ext_q;
  logic [28:0] id_q;
  logic [3:0]  len_q;
  logic [7:0]  data_q [8];
  logic [3:0]  cnt_q, cnt_d;
  logic        out_valid_q;
  logic [7:0]  byte_q;
  logic        last_q;

  logic [31:0] id_pad;
  logic [3:0]  id_nib;
  logic [7:0]  data_byte;
  logic [3:0]  data_nib;
  logic [4:0]  last_nib_idx;
  logic [7:0]  char_d;

  assign id_pad       = {3'b000, id_q};
  assign id_nib       = id_pad[{cnt_q[2:0], 2'b00} +: 4];
  assign data_byte    = data_q[cnt_q[3:1]];
  assign data_nib     = cnt_q[0] ? data_byte[3:0] : data_byte[7:4];
  assign last_nib_idx = {len_q, 1'b0} - 5'd1;

  assign status_o.out_free  = !out_valid_q || !out_stall_i;
  assign status_o.cnt_zero  = (cnt_q == 4'd0);
  assign status_o.data_last = ({1'b0, cnt_q} == last_nib_idx);
  assign status_o.len_zero  = (len_q == 4'd0);

  always_comb begin
    case (cmd_i.sel)
      slcan_pkg::SEL_HEAD: char_d = ext_q ? slcan_pkg::CharExt : slcan_pkg::CharStd;
      slcan_pkg::SEL_ID:   char_d = slcan_pkg::hex_char(id_nib);
      slcan_pkg::SEL_LEN:  char_d = slcan_pkg::CharZero + {4'b0000, len_q};
      slcan_pkg::SEL_DATA: char_d = slcan_pkg::hex_char(data_nib);
      slcan_pkg::SEL_CR:   char_d = slcan_pkg::CharCr;
      default:             char_d = slcan_pkg::CharCr;
    endcase
  end

  always_comb begin
    case (cmd_i.cnt_op)
      slcan_pkg::CNT_LOAD_ID: cnt_d = ext_q ? slcan_pkg::ExtDigitTop : slcan_pkg::StdDigitTop;
      slcan_pkg::CNT_CLEAR:   cnt_d = 4'd0;
      slcan_pkg::CNT_INC:     cnt_d = cnt_q + 4'd1;
      slcan_pkg::CNT_DEC:     cnt_d = cnt_q - 4'd1;
      default:                cnt_d = cnt_q;
    endcase
  end

  // Frame capture; mask standard identifiers and saturate the length.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_frame) begin
      ext_q  <= is_extended_i;
      id_q   <= is_extended_i ? can_id_i : {18'd0, can_id_i[10:0]};
      len_q  <= (dlc_i > slcan_pkg::MaxLen) ? slcan_pkg::MaxLen : dlc_i;
      data_q <= data_i;
    end
    cnt_q <= cnt_d;
    if (cmd_i.emit) begin
      byte_q <= char_d;
      last_q <= (cmd_i.sel == slcan_pkg::SEL_CR);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign ascii_byte_o = byte_q;
  assign last_byte_o  = last_q;

endmodule

[sv/can_frame_to_slcan_ascii.sv]
// Top level of the SLCAN (Lawicel) ASCII frame encoder.
// Instantiates slcan_ctrl and slcan_dp; depends on slcan_pkg.

// One CAN frame per input transaction becomes one SLCAN text line, sent as
// one ASCII character per output transaction: 't' plus three hex digits of
// the 11-bit identifier, or 'T' plus eight hex digits of the 29-bit
// identifier, then the length digit, two lower-case hex digits per data
// byte and a closing CR flagged by last_byte_o. Length codes above eight
// send eight bytes. The sequencer emits one character per cycle into a
// single output register while the output does not stall; a line holds
// 6 to 27 characters. A new frame is accepted once the CR has been
// loaded into the output register, even while that CR still waits to
// be taken.
module can_frame_to_slcan_ascii (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        is_extended_i,
  input  logic [28:0] can_id_i,
  input  logic [3:0]  dlc_i,
  input  logic [7:0]  data_0_i,
  input  logic [7:0]  data_1_i,
  input  logic [7:0]  data_2_i,
  input  logic [7:0]  data_3_i,
  input  logic [7:0]  data_4_i,
  input  logic [7:0]  data_5_i,
  input  logic [7:0]  data_6_i,
  input  logic [7:0]  data_7_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  ascii_byte_o,
  output logic        last_byte_o
);

  slcan_pkg::cmd_t    cmd;
  slcan_pkg::status_t status;
  logic [7:0]         data_bytes [8];

  // Gather the data byte ports in frame order.
  assign data_bytes[0] = data_0_i;
  assign data_bytes[1] = data_1_i;
  assign data_bytes[2] = data_2_i;
  assign data_bytes[3] = data_3_i;
  assign data_bytes[4] = data_4_i;
  assign data_bytes[5] = data_5_i;
  assign data_bytes[6] = data_6_i;
  assign data_bytes[7] = data_7_i;

  // Sequence the line; hold the input stalled until the CR is loaded.
  slcan_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .status_i   (status),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  // Capture the frame, pick each character and drive the output register.
  slcan_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .is_extended_i (is_extended_i),
    .can_id_i      (can_id_i),
    .dlc_i         (dlc_i),
    .data_i        (data_bytes),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .ascii_byte_o  (ascii_byte_o),
    .last_byte_o   (last_byte_o)
  );

  // After a frame is accepted the encoder stays busy for its line.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after frame transaction");

  // A taken character that is not the CR is followed at once by the next one.
  a_no_gap_in_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !last_byte_o) |=> out_valid_o)
    else $error("gap inside an SLCAN line");

  // The last-byte flag marks the carriage return only.
  a_last_is_cr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_byte_o) |-> (ascii_byte_o == slcan_pkg::CharCr))
    else $error("last byte is not CR");

  // While a line is still being sent no new frame is taken.
  a_stall_mid_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !last_byte_o) |-> in_stall_o)
    else $error("input open in the middle of a line");

endmodule

[tb/sv/tb.sv]
// Self-checking testbench for can_frame_to_slcan_ascii (SLCAN line encoder).
// Needs only the RTL: sv/slcan_pkg.sv and sv/can_frame_to_slcan_ascii.sv with
// its submodules. Drives CAN frames in and checks every ASCII byte out.
`timescale 1ns / 100ps

module tb;

  // One received CAN frame as the sender offers it. The payload holds data_0
  // in its top byte, so a hex literal reads in frame order.
  typedef struct packed {
    logic        ext;
    logic [28:0] id;
    logic [3:0]  dlc;
    logic [63:0] payload;
  } can_frame_t;

  // One character of the expected text line.
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } line_char_t;

  // Directed row: the frame, plus the text line typed in by hand (without the
  // closing CR) where it is obvious. An empty string leaves it to the encoder
  // model below.
  typedef struct {
    can_frame_t frame;
    string      golden;
  } stim_row_t;

  localparam int NumDirected   = 18;
  localparam int FramesPerMode = 112;
  localparam int LongHoldCycles = 300;
  localparam int DrainCycles   = 40;
  localparam int CycleLimit    = 400000;

  localparam logic [7:0] AsciiStd = "t";
  localparam logic [7:0] AsciiExt = "T";
  localparam logic [7:0] AsciiCr  = 8'h0D;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        is_extended_i = 1'b0;
  logic [28:0] can_id_i = '0;
  logic [3:0]  dlc_i = '0;
  logic [7:0]  data_0_i = '0;
  logic [7:0]  data_1_i = '0;
  logic [7:0]  data_2_i = '0;
  logic [7:0]  data_3_i = '0;
  logic [7:0]  data_4_i = '0;
  logic [7:0]  data_5_i = '0;
  logic [7:0]  data_6_i = '0;
  logic [7:0]  data_7_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  ascii_byte_o;
  logic        last_byte_o;

  line_char_t  line_chars_q[$];
  int          mismatch_cnt = 0;
  int          cycle_cnt = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  logic        long_hold_req = 1'b0;
  logic        long_hold_done = 1'b0;

  stim_row_t directed_rows [NumDirected] = '{
    // extremes of the standard identifier, empty frames
    '{'{1'b0, 29'h0000000, 4'd0, 64'h0}, "t0000"},
    '{'{1'b0, 29'h00007ff, 4'd0, 64'h0}, "t7ff0"},
    // identifier bits above bit 10 are dropped on a standard frame
    '{'{1'b0, 29'h1ffff923, 4'd1, 64'hab00000000000000}, "t1231ab"},
    // extremes of the extended identifier, longest line
    '{'{1'b1, 29'h0000000, 4'd0, 64'h0}, "T000000000"},
    '{'{1'b1, 29'h1fffffff, 4'd8, 64'hffffffffffffffff}, "T1fffffff8ffffffffffffffff"},
    // length code above eight saturates to eight bytes
    '{'{1'b0, 29'h00005a5, 4'd15, 64'h0001020304050607}, "t5a580001020304050607"},
    // bytes past the length are ignored; digit 9 next to letter a
    '{'{1'b0, 29'h000009a, 4'd2, 64'h09a0ffffffffffff}, "t09a209a0"},
    '{'{1'b1, 29'h10000000, 4'd4, 64'h807f01fe55555555}, "T100000004807f01fe"},
    // remaining lengths, left to the model
    '{'{1'b0, 29'h0000123, 4'd1, 64'h5affffffffffffff}, ""},
    '{'{1'b0, 29'h0000456, 4'd3, 64'h1234567890abcdef}, ""},
    '{'{1'b0, 29'h1fff0789, 4'd5, 64'hfedcba9876543210}, ""},
    '{'{1'b0, 29'h00003bc, 4'd7, 64'hc3a50f1e2d3c4b5a}, ""},
    '{'{1'b1, 29'h0abcdef1, 4'd2, 64'h0a0b0c0d0e0f1011}, ""},
    '{'{1'b1, 29'h15555555, 4'd6, 64'h8899aabbccddeeff}, ""},
    '{'{1'b1, 29'h0aaaaaaa, 4'd8, 64'h0102030405060708}, ""},
    '{'{1'b0, 29'h00004d2, 4'd9, 64'hdeadbeefcafef00d}, ""},
    '{'{1'b1, 29'h01234567, 4'd12, 64'h7766554433221100}, ""},
    '{'{1'b1, 29'h1e0f0f0f, 4'd15, 64'h00ff00ff00ff00ff}, ""}
  };

  can_frame_to_slcan_ascii dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .is_extended_i (is_extended_i),
    .can_id_i      (can_id_i),
    .dlc_i         (dlc_i),
    .data_0_i      (data_0_i),
    .data_1_i      (data_1_i),
    .data_2_i      (data_2_i),
    .data_3_i      (data_3_i),
    .data_4_i      (data_4_i),
    .data_5_i      (data_5_i),
    .data_6_i      (data_6_i),
    .data_7_i      (data_7_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .ascii_byte_o  (ascii_byte_o),
    .last_byte_o   (last_byte_o)
  );

  always #6 clk_i = ~clk_i;

  // Lower-case hex digit for one nibble.
  function automatic logic [7:0] hex_ascii(input logic [3:0] nib);
    if (nib < 4'd10) begin
      return "0" + {4'b0000, nib};
    end
    return "a" + {4'b0000, nib} - 8'd10;
  endfunction

  function automatic void push_char(input logic [7:0] ch, input logic last);
    line_char_t entry;
    entry.ch = ch;
    entry.last = last;
    line_chars_q.push_back(entry);
  endfunction

  // Queue the SLCAN line for one accepted frame: from the typed-in text when
  // there is one, else encoded here from the frame fields.
  function automatic void expect_slcan_line(input can_frame_t f, input string golden);
    int          i;
    int          nbytes;
    logic [31:0] id_word;
    logic [7:0]  data_byte;
    if (golden.len() != 0) begin
      for (i = 0; i < golden.len(); i++) begin
        push_char(golden[i], 1'b0);
      end
    end else begin
      nbytes = (f.dlc > 4'd8) ? 8 : int'(f.dlc);
      if (f.ext) begin
        id_word = {3'b000, f.id};
        push_char(AsciiExt, 1'b0);
        for (i = 7; i >= 0; i--) begin
          push_char(hex_ascii(id_word[4*i +: 4]), 1'b0);
        end
      end else begin
        id_word = {21'd0, f.id[10:0]};
        push_char(AsciiStd, 1'b0);
        for (i = 2; i >= 0; i--) begin
          push_char(hex_ascii(id_word[4*i +: 4]), 1'b0);
        end
      end
      push_char("0" + nbytes[7:0], 1'b0);
      for (i = 0; i < nbytes; i++) begin
        data_byte = f.payload[63 - 8*i -: 8];
        push_char(hex_ascii(data_byte[7:4]), 1'b0);
        push_char(hex_ascii(data_byte[3:0]), 1'b0);
      end
    end
    push_char(AsciiCr, 1'b1);
  endfunction

  // Offer one frame and return at the rising edge that takes it. Called at a
  // rising edge; the sender may first idle at random.
  task automatic offer_frame(input can_frame_t f, input string golden);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    is_extended_i <= f.ext;
    can_id_i      <= f.id;
    dlc_i         <= f.dlc;
    data_0_i      <= f.payload[63:56];
    data_1_i      <= f.payload[55:48];
    data_2_i      <= f.payload[47:40];
    data_3_i      <= f.payload[39:32];
    data_4_i      <= f.payload[31:24];
    data_5_i      <= f.payload[23:16];
    data_6_i      <= f.payload[15:8];
    data_7_i      <= f.payload[7:0];
    // Sample the handshake mid-cycle, where it has settled; the transaction
    // then happens at the next rising edge.
    do begin
      @(negedge clk_i);
    end while (in_stall_o);
    expect_slcan_line(f, golden);
    @(posedge clk_i);
  endtask

  // Hold the sender off until every queued character has come out.
  task automatic drain_lines();
    in_valid_i <= 1'b0;
    while (line_chars_q.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Mostly legal lengths, now and then a length code that saturates; all
  // identifier and data bits random, including bytes past the length.
  function automatic can_frame_t random_frame();
    can_frame_t f;
    f.ext = 1'($urandom_range(1));
    f.id = 29'($urandom());
    if ($urandom_range(9) == 0) begin
      f.dlc = 4'($urandom_range(15, 9));
    end else begin
      f.dlc = 4'($urandom_range(8));
    end
    f.payload = {$urandom(), $urandom()};
    return f;
  endfunction

  // Receiver: stall at the current rate, or hold off for a long stretch once
  // asked to, so the encoder fills up and pushes back on the sender.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (long_hold_req && !long_hold_done) begin
        hold_left = LongHoldCycles;
        long_hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Output check: each character taken is compared with the oldest one
  // expected. Sample mid-cycle so edge ordering cannot matter.
  always @(negedge clk_i) begin
    line_char_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (line_chars_q.size() == 0) begin
        mismatch_cnt++;
        $display("%0t: unexpected character, expected none actual %h last %b",
                 $time, ascii_byte_o, last_byte_o);
      end else begin
        want = line_chars_q.pop_front();
        if (ascii_byte_o !== want.ch) begin
          mismatch_cnt++;
          $display("%0t: ascii_byte mismatch, expected %h actual %h",
                   $time, want.ch, ascii_byte_o);
        end
        if (last_byte_o !== want.last) begin
          mismatch_cnt++;
          $display("%0t: last_byte mismatch, expected %b actual %b",
                   $time, want.last, last_byte_o);
        end
      end
    end
  end

  // Stop a hung run.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int row;
    int mode;
    int n;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed frames under the first idling mix.
    send_idle_pct = 14;
    recv_idle_pct = 62;
    for (row = 0; row < NumDirected; row++) begin
      offer_frame(directed_rows[row].frame, directed_rows[row].golden);
    end

    // Random frames in three idling mixes; drain the encoder between them.
    for (mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          send_idle_pct = 14;
          recv_idle_pct = 62;
        end
        1: begin
          send_idle_pct = 62;
          recv_idle_pct = 14;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (n = 0; n < FramesPerMode; n++) begin
        // With neither side idling, block the receiver for a while and keep
        // the sender offering frames into the stalled encoder.
        if (mode == 2 && n == 8) begin
          long_hold_req = 1'b1;
        end
        offer_frame(random_frame(), "");
      end
      drain_lines();
    end

    // Let any stray character show up before the verdict.
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_cnt == 0 && line_chars_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
